[hdl/itq_pkg.sv]
// ----------------------------------------------------------------------------
// itq_pkg - shared types and constants for the tilt-to-quaternion core
// Fixed-point widths, Q30 angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package itq_pkg;

  // Vectoring datapath width (counts scaled by 2^14, plus CORDIC growth)
  localparam int VW        = 34;
  // Vectoring angle accumulator, Q30, holds +-(pi + sum of table)
  localparam int ZW        = 36;
  // Euler angle width, units of 2^-ANGLE_FRAC_BITS rad
  localparam int AW        = 34;
  // Half angle in Q30 plus the reduction offset
  localparam int HW        = 48;
  // Rotation datapath width (x, y, z)
  localparam int RW        = 34;
  // cos / sin in Q20
  localparam int TW        = 23;
  // Output word width, Q1.14
  localparam int OW        = 16;

  localparam int SQ_BITS   = 30;   // root bits of (ay^2 + az^2) << 28
  localparam int RADW      = 62;   // radicand / remainder width
  localparam int SQ_SHIFT  = 28;
  localparam int VEC_SHIFT = 14;   // counts to vectoring scale
  localparam int RED_STEPS = 14;   // reduction covers up to 2*pi*2^(RED_STEPS+1)
  localparam int TRIG_FRAC = 20;
  localparam int TRIG_SH   = 30 - TRIG_FRAC;
  localparam int OUT_SH    = 3 * TRIG_FRAC - 14;

  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [ZW-1:0] PI_Z     = 36'sd3373259426;
  localparam logic [HW-1:0]        PI_R     = 48'd3373259426;
  localparam logic [HW-1:0]        HALF_R   = 48'd1686629713;
  localparam logic [HW-1:0]        TWO_PI_R = 48'd6746518852;
  // 2*pi - pi/2 with the rounded constants: upper fold point
  localparam logic [HW-1:0]        FOLD_R   = 48'd5059889139;
  localparam logic [HW-1:0]        RED_OFFSET = TWO_PI_R << RED_STEPS;
  localparam logic signed [RW-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic signed [OW-1:0] OUT_ONE  = 16'sd16384;

  // floor(atan(2^-i) * 2^30)
  localparam logic [29:0] ATAN_TAB [ATAN_ENTRIES] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [ZW-1:0] zang_t;
  typedef logic signed [AW-1:0] angle_t;
  typedef logic signed [TW-1:0] trig_t;

  typedef struct packed {
    logic signed [OW-1:0] w;
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
  } quat_t;

endpackage

`default_nettype wire

[hdl/itq_isqrt.sv]
// ----------------------------------------------------------------------------
// itq_isqrt - pipelined integer square root
// floor(sqrt((a + b) << 28)), one restoring root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module itq_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [31:0]                  sq_a,
  input  logic [31:0]                  sq_b,
  output logic                         out_valid,
  output logic [itq_pkg::SQ_BITS-1:0]  root
);
  import itq_pkg::*;

  logic [RADW-1:0]    rem   [0:SQ_BITS];
  logic [SQ_BITS-1:0] rt    [0:SQ_BITS];
  logic               vld   [0:SQ_BITS];
  logic [RADW-1:0]    trial [0:SQ_BITS-1];

  // stage j settles root bit SQ_BITS-1-j
  always_comb begin
    for (int j = 0; j < SQ_BITS; j++) begin
      trial[j] = (RADW'(rt[j]) << (SQ_BITS - j)) + (RADW'(1) << (2 * (SQ_BITS - 1 - j)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= SQ_BITS; j++) begin
        vld[j] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int j = 0; j < SQ_BITS; j++) begin
        vld[j+1] <= vld[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RADW'({1'b0, sq_a} + {1'b0, sq_b}) << SQ_SHIFT;
      rt[0]  <= '0;
      for (int j = 0; j < SQ_BITS; j++) begin
        if (rem[j] >= trial[j]) begin
          rem[j+1] <= rem[j] - trial[j];
          rt[j+1]  <= rt[j] | (SQ_BITS'(1) << (SQ_BITS - 1 - j));
        end else begin
          rem[j+1] <= rem[j];
          rt[j+1]  <= rt[j];
        end
      end
    end
  end

  assign out_valid = vld[SQ_BITS];
  assign root      = rt[SQ_BITS];

endmodule

`default_nettype wire

[hdl/itq_atan2.sv]
// ----------------------------------------------------------------------------
// itq_atan2 - pipelined CORDIC vectoring, atan2(y, x) in Q30
// Left half-plane folded in the entry stage; atan2(0,0) forced to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module itq_atan2 #(
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  itq_pkg::vec_t        y_in,
  input  itq_pkg::vec_t        x_in,
  output logic                 out_valid,
  output itq_pkg::zang_t       angle
);
  import itq_pkg::*;

  vec_t  xs [0:STEPS];
  vec_t  ys [0:STEPS];
  zang_t zs [0:STEPS];
  logic  zf [0:STEPS];
  logic  vld [0:STEPS];
  vec_t  dx [0:STEPS-1];
  vec_t  dy [0:STEPS-1];
  zang_t at [0:STEPS-1];

  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      dx[i] = ys[i] >>> i;
      dy[i] = xs[i] >>> i;
      at[i] = $signed(ZW'(ATAN_TAB[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= STEPS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 0; i < STEPS; i++) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[VW-1]) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= y_in[VW-1] ? -PI_Z : PI_Z;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
      for (int i = 0; i < STEPS; i++) begin
        zf[i+1] <= zf[i];
        if (ys[i][VW-1]) begin
          xs[i+1] <= xs[i] - dx[i];
          ys[i+1] <= ys[i] + dy[i];
          zs[i+1] <= zs[i] - at[i];
        end else begin
          xs[i+1] <= xs[i] + dx[i];
          ys[i+1] <= ys[i] - dy[i];
          zs[i+1] <= zs[i] + at[i];
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign angle     = zf[STEPS] ? '0 : zs[STEPS];

endmodule

`default_nettype wire

[hdl/itq_sincos.sv]
// ----------------------------------------------------------------------------
// itq_sincos - pipelined half-angle reduction and CORDIC rotation
// Half angle to Q30, reduced mod 2*pi, folded to +-pi/2, cos/sin in Q20.
// ----------------------------------------------------------------------------
`default_nettype none

module itq_sincos #(
  parameter int FRAC  = 12,
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  itq_pkg::angle_t    angle,
  output logic               out_valid,
  output itq_pkg::trig_t     cos_v,
  output itq_pkg::trig_t     sin_v
);
  import itq_pkg::*;

  localparam int RN = RED_STEPS + 1;
  localparam int LAT = RN + STEPS + 3;
  localparam logic signed [RW-1:0] RND = RW'(1) << (TRIG_SH - 1);

  logic [HW-1:0]          m   [0:RN];
  logic [HW-1:0]          sub [0:RN-1];
  logic signed [HW-1:0]   h0;
  logic [HW-1:0]          fd;
  logic                   fneg;
  logic signed [RW-1:0]   xs [0:STEPS];
  logic signed [RW-1:0]   ys [0:STEPS];
  logic signed [RW-1:0]   zs [0:STEPS];
  logic                   ng [0:STEPS];
  logic signed [RW-1:0]   dx [0:STEPS-1];
  logic signed [RW-1:0]   dy [0:STEPS-1];
  logic signed [RW-1:0]   at [0:STEPS-1];
  logic signed [RW-1:0]   xr;
  logic signed [RW-1:0]   yr;
  logic [LAT-1:0]         vld;

  always_comb begin
    h0 = HW'(angle) <<< (29 - FRAC);
    for (int j = 0; j < RN; j++) begin
      sub[j] = TWO_PI_R << (RED_STEPS - j);
    end
    // fold the [0, 2*pi) residue into [-pi/2, pi/2]
    fneg = 1'b0;
    if (m[RN] <= HALF_R) begin
      fd = m[RN];
    end else if (m[RN] < FOLD_R) begin
      fd   = m[RN] - PI_R;
      fneg = 1'b1;
    end else begin
      fd = m[RN] - TWO_PI_R;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx[i] = ys[i] >>> i;
      dy[i] = xs[i] >>> i;
      at[i] = $signed(RW'(ATAN_TAB[i]));
    end
    xr = (xs[STEPS] + RND) >>> TRIG_SH;
    yr = (ys[STEPS] + RND) >>> TRIG_SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= unsigned'(h0) + RED_OFFSET;
      for (int j = 0; j < RN; j++) begin
        m[j+1] <= (m[j] >= sub[j]) ? m[j] - sub[j] : m[j];
      end
      xs[0] <= GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= fd[RW-1:0];
      ng[0] <= fneg;
      for (int i = 0; i < STEPS; i++) begin
        ng[i+1] <= ng[i];
        if (!zs[i][RW-1]) begin
          xs[i+1] <= xs[i] - dx[i];
          ys[i+1] <= ys[i] + dy[i];
          zs[i+1] <= zs[i] - at[i];
        end else begin
          xs[i+1] <= xs[i] + dx[i];
          ys[i+1] <= ys[i] - dy[i];
          zs[i+1] <= zs[i] + at[i];
        end
      end
      cos_v <= ng[STEPS] ? -xr[TW-1:0] : xr[TW-1:0];
      sin_v <= ng[STEPS] ? -yr[TW-1:0] : yr[TW-1:0];
    end
  end

  assign out_valid = vld[LAT-1];

endmodule

`default_nettype wire

[hdl/imu_tilt_to_quaternion_core.sv]
// Throughput: one sample word per clock while the skid register is empty; every
// stage through P4 advances on a common enable. The output register is backed by
// a one-word skid register, so the pipeline only freezes once a result is held in
// the skid register under output stall. Reset (synchronous, rst high) clears every
// valid flag and loads time_step = 655.
// ----------------------------------------------------------------------------
// imu_tilt_to_quaternion_core - accelerometer tilt and gyro step to quaternion
// Pitch/roll by CORDIC vectoring, gyro*dt added, half-angle sin/cos by CORDIC
// rotation, Euler-to-quaternion products out in Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_tilt_to_quaternion_core #(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  // quaternion channel
  output logic               quat_valid,
  input  logic               quat_stall,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);
  import itq_pkg::*;

  // Stage plan:
  //   F      : register inputs, squares of ay/az and rate*time_step products
  //   SQ     : 1 + SQ_BITS stages of root extraction for the pitch magnitude
  //   AT     : 1 + CORDIC_STEPS vectoring stages (pitch and roll side by side)
  //   A      : round arctangents, add gyro terms -> three Euler angles
  //   SC     : reduction, fold and rotation for each half angle
  //   P1..P4 : pair products, triple products, sums, round and saturate
  //   out    : output register plus skid register
  localparam int GSH    = 16 - ANGLE_FRAC_BITS;        // gyro term rounding shift
  localparam int ASH    = 30 - ANGLE_FRAC_BITS;        // Q30 arctangent to angle
  localparam int L_SQ   = SQ_BITS + 1;
  localparam int L_AT   = CORDIC_STEPS + 1;
  localparam int L_G    = L_SQ + L_AT;
  localparam int GW     = 33;
  localparam int P1W    = 2 * TW;
  localparam int P2W    = 3 * TW;
  localparam int SW     = P2W + 1;
  localparam logic signed [ZW-1:0] ARND  = ZW'(1) << (ASH - 1);
  localparam logic signed [SW-1:0] SRND  = SW'(1) << (OUT_SH - 1);
  localparam logic signed [SW-1:0] S_MAX = SW'(OUT_ONE);
  localparam logic signed [SW-1:0] S_MIN = -SW'(OUT_ONE);

  function automatic logic signed [OW-1:0] sat_q14(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + SRND) >>> OUT_SH;
    if (t > S_MAX) begin
      return OUT_ONE;
    end else if (t < S_MIN) begin
      return -OUT_ONE;
    end
    return t[OW-1:0];
  endfunction

  // -------------------------------------------------------------------------
  // Configuration: sample period; unchecked by the core, the user must write it only while the core is idle
  // -------------------------------------------------------------------------
  logic [15:0] time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 16'd655;
    end else if (cfg_we) begin
      time_step <= cfg_wdata;
    end
  end

  // -------------------------------------------------------------------------
  // Pipeline enable: the whole datapath moves unless the skid word is full
  // -------------------------------------------------------------------------
  logic  en;
  logic  skid_full;
  logic  out_full;

  assign en           = !skid_full;
  assign sample_stall = skid_full;

  // -------------------------------------------------------------------------
  // F: front registers
  // -------------------------------------------------------------------------
  logic               f_valid;
  logic signed [15:0] f_ax, f_ay, f_az;
  logic [31:0]        f_ay2, f_az2;
  logic signed [GW-1:0] f_gx, f_gy, f_gz;
  logic signed [31:0] ay_sq, az_sq;
  logic signed [GW-1:0] gx_p, gy_p, gz_p;
  logic signed [GW-1:0] gt_x, gt_y, gt_z;

  always_comb begin
    ay_sq = accel_y * accel_y;
    az_sq = accel_z * accel_z;
    gx_p  = rate_x * $signed({1'b0, time_step});
    gy_p  = rate_y * $signed({1'b0, time_step});
    gz_p  = rate_z * $signed({1'b0, time_step});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_ax  <= accel_x;
      f_ay  <= accel_y;
      f_az  <= accel_z;
      f_ay2 <= ay_sq;
      f_az2 <= az_sq;
      f_gx  <= gx_p;
      f_gy  <= gy_p;
      f_gz  <= gz_p;
    end
  end

  // gyro term: rate*dt rounded from 2^-16 rad to the angle unit
  generate
    if (GSH > 0) begin : g_gyro_rnd
      localparam logic signed [GW-1:0] GRND = GW'(1) << (GSH - 1);
      assign gt_x = (f_gx + GRND) >>> GSH;
      assign gt_y = (f_gy + GRND) >>> GSH;
      assign gt_z = (f_gz + GRND) >>> GSH;
    end else begin : g_gyro_exact
      assign gt_x = f_gx;
      assign gt_y = f_gy;
      assign gt_z = f_gz;
    end
  endgenerate

  // -------------------------------------------------------------------------
  // SQ: pitch magnitude; accel counts and gyro terms ride alongside
  // -------------------------------------------------------------------------
  logic               sq_valid;
  logic [SQ_BITS-1:0] sq_root;
  logic signed [15:0] d_ax [0:L_SQ-1];
  logic signed [15:0] d_ay [0:L_SQ-1];
  logic signed [15:0] d_az [0:L_SQ-1];
  logic signed [GW-1:0] d_gx [0:L_G-1];
  logic signed [GW-1:0] d_gy [0:L_G-1];
  logic signed [GW-1:0] d_gz [0:L_G-1];

  itq_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .sq_a      (f_ay2),
    .sq_b      (f_az2),
    .out_valid (sq_valid),
    .root      (sq_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_ax[0] <= f_ax;
      d_ay[0] <= f_ay;
      d_az[0] <= f_az;
      for (int i = 1; i < L_SQ; i++) begin
        d_ax[i] <= d_ax[i-1];
        d_ay[i] <= d_ay[i-1];
        d_az[i] <= d_az[i-1];
      end
      d_gx[0] <= gt_x;
      d_gy[0] <= gt_y;
      d_gz[0] <= gt_z;
      for (int i = 1; i < L_G; i++) begin
        d_gx[i] <= d_gx[i-1];
        d_gy[i] <= d_gy[i-1];
        d_gz[i] <= d_gz[i-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // AT: pitch = atan2(-ax, |(ay, az)|), roll = atan2(ay, az), all scaled 2^14
  // -------------------------------------------------------------------------
  vec_t  pv_y, pv_x, rv_y, rv_x;
  logic  pa_valid, ra_valid;
  zang_t pa_q30, ra_q30;

  always_comb begin
    pv_y = -(VW'(d_ax[L_SQ-1]) <<< VEC_SHIFT);
    pv_x = VW'({1'b0, sq_root});
    rv_y = VW'(d_ay[L_SQ-1]) <<< VEC_SHIFT;
    rv_x = VW'(d_az[L_SQ-1]) <<< VEC_SHIFT;
  end

  itq_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .y_in      (pv_y),
    .x_in      (pv_x),
    .out_valid (pa_valid),
    .angle     (pa_q30)
  );

  itq_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .y_in      (rv_y),
    .x_in      (rv_x),
    .out_valid (ra_valid),
    .angle     (ra_q30)
  );

  // -------------------------------------------------------------------------
  // A: Euler angles in units of 2^-ANGLE_FRAC_BITS rad
  // -------------------------------------------------------------------------
  logic   a_valid;
  angle_t a_pitch, a_roll, a_yaw;
  zang_t  pa_rnd, ra_rnd;

  always_comb begin
    pa_rnd = (pa_q30 + ARND) >>> ASH;
    ra_rnd = (ra_q30 + ARND) >>> ASH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= pa_valid && ra_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pitch <= pa_rnd[AW-1:0] + AW'(d_gx[L_G-1]);
      a_roll  <= ra_rnd[AW-1:0] + AW'(d_gy[L_G-1]);
      a_yaw   <= AW'(d_gz[L_G-1]);
    end
  end

  // -------------------------------------------------------------------------
  // SC: half-angle cos and sin (angle value read as 2^-(FRAC+1) rad)
  // -------------------------------------------------------------------------
  logic  cp_valid, cr_valid, cy_valid;
  trig_t cp, sp, cr, sr, cy, sy;

  itq_sincos #(.FRAC(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_sc_pitch (
    .clk (clk), .rst (rst), .en (en), .in_valid (a_valid), .angle (a_pitch),
    .out_valid (cp_valid), .cos_v (cp), .sin_v (sp)
  );

  itq_sincos #(.FRAC(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_sc_roll (
    .clk (clk), .rst (rst), .en (en), .in_valid (a_valid), .angle (a_roll),
    .out_valid (cr_valid), .cos_v (cr), .sin_v (sr)
  );

  itq_sincos #(.FRAC(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_sc_yaw (
    .clk (clk), .rst (rst), .en (en), .in_valid (a_valid), .angle (a_yaw),
    .out_valid (cy_valid), .cos_v (cy), .sin_v (sy)
  );

  // -------------------------------------------------------------------------
  // P1..P4: two multiplier levels of quaternion products, then sums, then round and saturate, one per stage
  // -------------------------------------------------------------------------
  logic                  p1_valid, p2_valid, p3_valid, p4_valid;
  logic signed [P1W-1:0] p1_a, p1_b, p1_c, p1_d;   // cr.cp, sr.sp, sr.cp, cr.sp
  trig_t                 p1_cy, p1_sy;
  logic signed [P2W-1:0] p2_w0, p2_w1, p2_x0, p2_x1, p2_y0, p2_y1, p2_z0, p2_z1;
  logic signed [SW-1:0]  p3_w, p3_x, p3_y, p3_z;
  quat_t                 p4_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= cp_valid && cr_valid && cy_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_a  <= cr * cp;
      p1_b  <= sr * sp;
      p1_c  <= sr * cp;
      p1_d  <= cr * sp;
      p1_cy <= cy;
      p1_sy <= sy;

      p2_w0 <= p1_a * p1_cy;
      p2_w1 <= p1_b * p1_sy;
      p2_x0 <= p1_c * p1_cy;
      p2_x1 <= p1_d * p1_sy;
      p2_y0 <= p1_d * p1_cy;
      p2_y1 <= p1_c * p1_sy;
      p2_z0 <= p1_a * p1_sy;
      p2_z1 <= p1_b * p1_cy;

      p3_w  <= SW'(p2_w0) + SW'(p2_w1);
      p3_x  <= SW'(p2_x0) - SW'(p2_x1);
      p3_y  <= SW'(p2_y0) + SW'(p2_y1);
      p3_z  <= SW'(p2_z0) - SW'(p2_z1);

      p4_q.w <= sat_q14(p3_w);
      p4_q.x <= sat_q14(p3_x);
      p4_q.y <= sat_q14(p3_y);
      p4_q.z <= sat_q14(p3_z);
    end
  end

  // -------------------------------------------------------------------------
  // Output register with skid word. A word leaving P4 while the output is
  // held lands in the skid register; only then does the pipeline freeze.
  // -------------------------------------------------------------------------
  quat_t out_q, skid_q;
  logic  out_free;

  assign out_free = !out_full || !quat_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_free) begin
        out_full  <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (out_free) begin
      out_full <= p4_valid;
    end else if (p4_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= p4_q;
    end else if (p4_valid) begin
      skid_q <= p4_q;
    end
  end

  assign quat_valid = out_full;
  assign quat_w     = out_q.w;
  assign quat_x     = out_q.x;
  assign quat_y     = out_q.y;
  assign quat_z     = out_q.z;

endmodule

`default_nettype wire

[hdl/itq_checker.sv]
// ----------------------------------------------------------------------------
// itq_checker - port-level checks for the tilt-to-quaternion core
// Attached to the top level by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
`default_nettype none

module itq_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic               quat_valid,
  input logic               quat_stall,
  input logic signed [15:0] quat_w,
  input logic signed [15:0] quat_x,
  input logic signed [15:0] quat_y,
  input logic signed [15:0] quat_z
);

  // held output word stays put
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    quat_valid && quat_stall |=> quat_valid && $stable(quat_w) && $stable(quat_x)
      && $stable(quat_y) && $stable(quat_z))
    else $error("output word changed under stall");

  // saturation keeps every component within one
  a_range : assert property (@(posedge clk) disable iff (rst)
    quat_valid |-> quat_w >= -16'sd16384 && quat_w <= 16'sd16384
      && quat_x >= -16'sd16384 && quat_x <= 16'sd16384
      && quat_y >= -16'sd16384 && quat_y <= 16'sd16384
      && quat_z >= -16'sd16384 && quat_z <= 16'sd16384)
    else $error("quaternion component out of range");

  // reset empties the output and skid words
  a_reset : assert property (@(posedge clk)
    rst |=> !quat_valid && !sample_stall)
    else $error("output not empty after reset");

  // input only backs up after a held output word
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    sample_stall && sample_valid |-> $past(quat_valid && quat_stall))
    else $error("input stalled without output back-pressure");

endmodule

bind imu_tilt_to_quaternion_core itq_checker u_itq_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - regression for the IMU tilt-to-quaternion core
// Drives sensor sample words with random idling on both channels. A
// behavioural fixed-point model predicts each quaternion word. Results are
// checked in order, field by field, under several time_step settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import itq_pkg::*;

  localparam longint PI_Q     = 64'sd3373259426;
  localparam longint TWO_PI_Q = 64'sd6746518852;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint GAIN_Q   = 64'sd652032874;
  localparam int     N_STEPS  = 16;
  localparam int     FRAC     = 12;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     DRAIN_CYCLES = 120;   // margin beyond the pipeline depth

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [15:0]       cfg_wdata = '0;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [15:0] rate_x = '0, rate_y = '0, rate_z = '0;
  logic              quat_valid;
  logic              quat_stall = 1'b0;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

  // predictor copy of the one register
  logic [15:0] dt_reg = 16'd655;
  quat_t       quat_pending[$];
  int          fail_count = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycle_count = 0;

  imu_tilt_to_quaternion_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
    .quat_valid(quat_valid), .quat_stall(quat_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Fixed-point model of the datapath
  // --------------------------------------------------------------------------
  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint floor_sqrt(logic [63:0] n);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return longint'(res);
  endfunction

  // vectoring arctangent, Q30
  function automatic longint vec_atan2(longint y, longint x);
    longint base, z, nx, ny;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? PI_Q : -PI_Q;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(ATAN_TAB[i]);
      end
      x = nx;
      y = ny;
    end
    return base + z;
  endfunction

  // rotation sin/cos of a Q30 angle, Q20 out; folded outside +-pi/2
  task automatic rot_sincos(input longint h, output longint c, output longint s);
    longint r, x, y, nx, ny;
    bit flip;
    r = h % TWO_PI_Q;
    x = GAIN_Q;
    y = 0;
    flip = 0;
    if (r < 0) r += TWO_PI_Q;
    if (r >= PI_Q) r -= TWO_PI_Q;
    if (r > HALF_PI_Q) begin
      r -= PI_Q;
      flip = 1;
    end else if (r < -HALF_PI_Q) begin
      r += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        r -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        r += longint'(ATAN_TAB[i]);
      end
      x = nx;
      y = ny;
    end
    c = rnd_shift(x, 10);
    s = rnd_shift(y, 10);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic logic signed [15:0] q14_sat(longint q60);
    longint v;
    v = rnd_shift(q60, 46);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  function automatic longint gyro_step(logic signed [15:0] rate);
    return rnd_shift(longint'(rate) * longint'({48'd0, dt_reg}), 16 - FRAC);
  endfunction

  task automatic predict_quat(input logic signed [15:0] ax, ay, az, gx, gy, gz,
                              output quat_t q);
    longint mag, pitch, roll, yaw, cp, sp, cr, sr, cy, sy;
    logic [63:0] sq;
    sq = (64'(longint'(ay) * longint'(ay)) + 64'(longint'(az) * longint'(az))) << 28;
    mag = floor_sqrt(sq);
    pitch = rnd_shift(vec_atan2(-longint'(ax) * 16384, mag), 30 - FRAC) + gyro_step(gx);
    roll  = rnd_shift(vec_atan2(longint'(ay) * 16384, longint'(az) * 16384), 30 - FRAC)
            + gyro_step(gy);
    yaw   = gyro_step(gz);
    // angle in 2^-12 rad read as half angle in 2^-13, moved to Q30
    rot_sincos(pitch <<< (29 - FRAC), cp, sp);
    rot_sincos(roll <<< (29 - FRAC), cr, sr);
    rot_sincos(yaw <<< (29 - FRAC), cy, sy);
    q.w = q14_sat(cr * cp * cy + sr * sp * sy);
    q.x = q14_sat(sr * cp * cy - cr * sp * sy);
    q.y = q14_sat(cr * sp * cy + sr * cp * sy);
    q.z = q14_sat(cr * cp * sy - sr * sp * cy);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, in-order compare, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words outstanding", $time, quat_pending.size());
      $display("imu_tilt_to_quaternion_core regression: fail");
      $finish;
    end
    if (!rst && quat_valid && !quat_stall) begin
      if (quat_pending.size() == 0) begin
        $display("%0t: unexpected quaternion word w=%0d x=%0d y=%0d z=%0d",
                 $time, quat_w, quat_x, quat_y, quat_z);
        fail_count++;
      end else begin
        quat_t q;
        q = quat_pending.pop_front();
        words_checked++;
        if (quat_w !== q.w) begin
          $display("%0t: quat_w expected %0d actual %0d", $time, q.w, quat_w);
          fail_count++;
        end
        if (quat_x !== q.x) begin
          $display("%0t: quat_x expected %0d actual %0d", $time, q.x, quat_x);
          fail_count++;
        end
        if (quat_y !== q.y) begin
          $display("%0t: quat_y expected %0d actual %0d", $time, q.y, quat_y);
          fail_count++;
        end
        if (quat_z !== q.z) begin
          $display("%0t: quat_z expected %0d actual %0d", $time, q.z, quat_z);
          fail_count++;
        end
      end
    end
    quat_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------
  // Leaves valid high after acceptance; the next word or an idle cycle decides.
  task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz);
    quat_t q;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    accel_x <= ax;
    accel_y <= ay;
    accel_z <= az;
    rate_x <= gx;
    rate_y <= gy;
    rate_z <= gz;
    do @(posedge clk); while (sample_stall);
    predict_quat(ax, ay, az, gx, gy, gz, q);
    quat_pending.push_back(q);
    words_sent++;
  endtask

  task automatic drain_pipeline();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (quat_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register writes only with the pipeline empty
  task automatic set_time_step(input logic [15:0] v);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dt_reg = v;
  endtask

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($signed($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_sample(0, 0, 0, 0, 0, 0);                          // atan2(0,0) both
    send_sample(16'sh7fff, 0, 0, 0, 0, 0);                  // pitch only, ax max
    send_sample(16'sh8000, 0, 0, 0, 0, 0);                  // ax min
    send_sample(0, 0, -16384, 0, 0, 0);                     // upside down: roll pi
    send_sample(0, 0, 16'sh8000, 100, -100, 50);
    send_sample(0, 0, 16384, 0, 0, 0);                      // level
    send_sample(0, 16'sh7fff, 0, 0, 0, 0);
    send_sample(0, 16'sh8000, 0, 0, 0, 0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff); // gyro only
    send_sample(-3000, 2000, 15000, 2, -1, 3);
    set_time_step(16'hffff);
    send_sample(0, 0, 16384, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(0, 0, 16384, 1, -1, 16'sh8000);
    set_time_step(16'd0);                                   // gyro adds nothing
    send_sample(1000, -500, 16000, 16'sh7fff, 16'sh8000, 12345);
    set_time_step(16'd1);
    send_sample(0, 0, -1, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(-1, 0, 1, -1, 1, -1);
    set_time_step(16'd655);
  endtask

  task automatic test_random(input int count);
    logic signed [15:0] ax, ay, az;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 60) begin
        // accel components uniform in -16000..16000, rates in -20..20 counts
        ax = 16'($signed($urandom_range(32000)) - 16000);
        ay = 16'($signed($urandom_range(32000)) - 16000);
        az = 16'($signed($urandom_range(32000)) - 16000);
        send_sample(ax, ay, az, 16'($signed($urandom_range(40)) - 20),
                    16'($signed($urandom_range(40)) - 20),
                    16'($signed($urandom_range(40)) - 20));
      end else begin
        send_sample(rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word());
      end
    end
  endtask

  task automatic test_idle_mode(input int snd, input int rcv, input int count);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    set_time_step(16'd655);
    test_random(count / 3);
    set_time_step(16'($urandom_range(65535, 1)));
    test_random(count / 3);
    set_time_step(16'hffff);
    test_random(count / 6);
    set_time_step(16'd1);
    test_random(count / 6);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_idle_mode(16, 49, 276);
    test_idle_mode(49, 16, 276);
    test_idle_mode(0, 0, 276);
    drain_pipeline();
    $display("Covered %0d sample words, %0d quaternion words checked, time_step 0..65535,",
             words_sent, words_checked);
    $display("with sender and receiver idling swapped and then off.");
    if (fail_count == 0) begin
      $display("imu_tilt_to_quaternion_core regression: pass");
    end else begin
      $display("imu_tilt_to_quaternion_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
